/* design/clts_pkg.sv */
// Package with token kinds, scanner modes and shared types of the token scanner.
`timescale 1ns / 1ps
package clts_pkg;

   localparam int KIND_BITS = 6;
   localparam int LEN_BITS  = 16;

   localparam logic [KIND_BITS-1:0] K_END     = 6'd0;
   localparam logic [KIND_BITS-1:0] K_IDENT   = 6'd1;
   localparam logic [KIND_BITS-1:0] K_BOOLLIT = 6'd16;
   localparam logic [KIND_BITS-1:0] K_COMMA   = 6'd17;
   localparam logic [KIND_BITS-1:0] K_SEMI    = 6'd18;
   localparam logic [KIND_BITS-1:0] K_COLON   = 6'd19;
   localparam logic [KIND_BITS-1:0] K_DOT     = 6'd20;
   localparam logic [KIND_BITS-1:0] K_LPAREN  = 6'd21;
   localparam logic [KIND_BITS-1:0] K_RPAREN  = 6'd22;
   localparam logic [KIND_BITS-1:0] K_LBRACE  = 6'd23;
   localparam logic [KIND_BITS-1:0] K_RBRACE  = 6'd24;
   localparam logic [KIND_BITS-1:0] K_LBRACK  = 6'd25;
   localparam logic [KIND_BITS-1:0] K_RBRACK  = 6'd26;
   localparam logic [KIND_BITS-1:0] K_PLUS    = 6'd27;
   localparam logic [KIND_BITS-1:0] K_MINUS   = 6'd28;
   localparam logic [KIND_BITS-1:0] K_STAR    = 6'd29;
   localparam logic [KIND_BITS-1:0] K_DIV     = 6'd30;
   localparam logic [KIND_BITS-1:0] K_MOD     = 6'd31;
   localparam logic [KIND_BITS-1:0] K_AND     = 6'd32;
   localparam logic [KIND_BITS-1:0] K_LAND    = 6'd33;
   localparam logic [KIND_BITS-1:0] K_OR      = 6'd34;
   localparam logic [KIND_BITS-1:0] K_LOR     = 6'd35;
   localparam logic [KIND_BITS-1:0] K_XOR     = 6'd36;
   localparam logic [KIND_BITS-1:0] K_TILDE   = 6'd37;
   localparam logic [KIND_BITS-1:0] K_NOT     = 6'd38;
   localparam logic [KIND_BITS-1:0] K_NE      = 6'd39;
   localparam logic [KIND_BITS-1:0] K_ASSIGN  = 6'd40;
   localparam logic [KIND_BITS-1:0] K_EQ      = 6'd41;
   localparam logic [KIND_BITS-1:0] K_LT      = 6'd42;
   localparam logic [KIND_BITS-1:0] K_LE      = 6'd43;
   localparam logic [KIND_BITS-1:0] K_SHL     = 6'd44;
   localparam logic [KIND_BITS-1:0] K_GT      = 6'd45;
   localparam logic [KIND_BITS-1:0] K_GE      = 6'd46;
   localparam logic [KIND_BITS-1:0] K_SHR     = 6'd47;
   localparam logic [KIND_BITS-1:0] K_ERROR   = 6'd48;

   localparam logic [7:0] CH_NL  = 8'h0A;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_SP  = 8'h20;

   // Keyword table, bytes packed low first, up to 8 bytes.
   localparam int NUM_KW = 16;
   localparam logic [63:0] KW_TEXT [NUM_KW] = '{
      64'h0000_006B_6165_7262, // break
      64'h0000_0000_6C6F_6F62, // bool
      64'h0000_0000_7261_6863, // char
      64'h0000_0074_736E_6F63, // const
      64'h0000_0000_6573_6C65, // else
      64'h0000_0000_0072_6F66, // for
      64'h0000_0074_616F_6C66, // float
      64'h0000_0000_0000_6669, // if
      64'h0000_0000_0074_6E69, // int
      64'h0000_6E72_7574_6572, // return
      64'h0000_676E_6972_7473, // string
      64'h0000_0000_0065_7375, // use
      64'h0000_0000_6469_6F76, // void
      64'h0000_0065_6C69_6877, // while
      64'h0000_0000_6575_7274, // true
      64'h0000_0065_736C_6166  // false
   };
   localparam logic [3:0] KW_LEN [NUM_KW] = '{
      4'd5, 4'd4, 4'd4, 4'd5, 4'd4, 4'd3, 4'd5, 4'd2,
      4'd3, 4'd6, 4'd6, 4'd3, 4'd4, 4'd5, 4'd4, 4'd5
   };
   localparam logic [KIND_BITS-1:0] KW_KIND [NUM_KW] = '{
      6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9,
      6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, K_BOOLLIT, K_BOOLLIT
   };

   typedef enum logic [11:0] {
      M_IDLE  = 12'b0000_0000_0001,
      M_WORD  = 12'b0000_0000_0010,
      M_SLASH = 12'b0000_0000_0100,
      M_LCOMM = 12'b0000_0000_1000,
      M_BCOMM = 12'b0000_0001_0000,
      M_BSTAR = 12'b0000_0010_0000,
      M_AMP   = 12'b0000_0100_0000,
      M_PIPE  = 12'b0000_1000_0000,
      M_BANG  = 12'b0001_0000_0000,
      M_EQ    = 12'b0010_0000_0000,
      M_LT    = 12'b0100_0000_0000,
      M_GT    = 12'b1000_0000_0000
   } mode_type;

   typedef struct packed {
      logic                 valid;
      logic [KIND_BITS-1:0] kind;
      logic                 at_word;    // start position is the pending token's
      logic [LEN_BITS-1:0]  length;
   } tok_type;

endpackage

/* design/clts_if.sv */
// Valid/ready channel interface used by the token scanner.
`timescale 1ns / 1ps
interface clts_if #(
   parameter int WIDTH = 8
) (
   input logic clock
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* design/clts_front.sv */
// Front end: per-byte classification, mode tracking and token formation.
`timescale 1ns / 1ps
module clts_front
   import clts_pkg::*;
#(
   parameter int KEYWORD_CHARS = 6,
   parameter int LINE_BITS     = 24,
   parameter int COL_BITS      = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [7:0]           in_ch,
   input  logic                 in_end,
   output logic                 q_push,
   input  logic                 q_room,
   output tok_type              q_first,
   output tok_type              q_second,
   output logic [LINE_BITS-1:0] q_first_line,
   output logic [COL_BITS-1:0]  q_first_col,
   output logic [LINE_BITS-1:0] q_second_line,
   output logic [COL_BITS-1:0]  q_second_col
);
   localparam int WB = 8 * KEYWORD_CHARS;

   mode_type               mode_ff, mode_in;
   logic [WB-1:0]          word_ff, word_in;
   logic [LEN_BITS-1:0]    wlen_ff, wlen_in;
   logic [LINE_BITS-1:0]   line_ff, line_in, tline_ff, tline_in;
   logic [COL_BITS-1:0]    col_ff, col_in, tcol_ff, tcol_in;
   logic                   done_ff;

   logic                   take;
   logic                   is_alpha, is_word;
   logic                   do_flush, do_start;
   tok_type                flush_tok, start_tok, pair_tok;
   logic [KIND_BITS-1:0]   wkind;
   mode_type               start_mode;

   assign in_ready = q_room;
   assign take     = in_valid && q_room && !done_ff;

   assign is_alpha = (in_ch inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || in_ch == 8'h5F;
   assign is_word  = is_alpha || (in_ch inside {[8'h30:8'h39]});

   always_comb begin
      wkind = K_IDENT;
      for (int i = NUM_KW - 1; i >= 0; i--) begin
         if (KW_LEN[i] <= 4'(KEYWORD_CHARS) && wlen_ff == LEN_BITS'(KW_LEN[i]) &&
             word_ff == KW_TEXT[i][WB-1:0]) begin
            wkind = KW_KIND[i];
         end
      end
   end

   always_comb begin
      flush_tok = '0;
      flush_tok.valid = 1'b1;
      flush_tok.length = LEN_BITS'(1);
      case (mode_ff)
         M_WORD: begin
            flush_tok.kind = wkind;
            flush_tok.length = wlen_ff;
         end
         M_SLASH: flush_tok.kind = K_DIV;
         M_AMP:   flush_tok.kind = K_AND;
         M_PIPE:  flush_tok.kind = K_OR;
         M_BANG:  flush_tok.kind = K_NOT;
         M_EQ:    flush_tok.kind = K_ASSIGN;
         M_LT:    flush_tok.kind = K_LT;
         M_GT:    flush_tok.kind = K_GT;
         default: flush_tok.valid = 1'b0;
      endcase
   end

   always_comb begin
      start_tok = '0;
      start_tok.valid = 1'b1;
      start_tok.length = LEN_BITS'(1);
      start_mode = M_IDLE;
      case (in_ch)
         CH_SP, CH_TAB, CH_NL: start_tok.valid = 1'b0;
         8'h2C: start_tok.kind = K_COMMA;
         8'h3B: start_tok.kind = K_SEMI;
         8'h3A: start_tok.kind = K_COLON;
         8'h2E: start_tok.kind = K_DOT;
         8'h28: start_tok.kind = K_LPAREN;
         8'h29: start_tok.kind = K_RPAREN;
         8'h7B: start_tok.kind = K_LBRACE;
         8'h7D: start_tok.kind = K_RBRACE;
         8'h5B: start_tok.kind = K_LBRACK;
         8'h5D: start_tok.kind = K_RBRACK;
         8'h2B: start_tok.kind = K_PLUS;
         8'h2D: start_tok.kind = K_MINUS;
         8'h2A: start_tok.kind = K_STAR;
         8'h25: start_tok.kind = K_MOD;
         8'h5E: start_tok.kind = K_XOR;
         8'h7E: start_tok.kind = K_TILDE;
         8'h2F: begin start_tok.valid = 1'b0; start_mode = M_SLASH; end
         8'h26: begin start_tok.valid = 1'b0; start_mode = M_AMP; end
         8'h7C: begin start_tok.valid = 1'b0; start_mode = M_PIPE; end
         8'h21: begin start_tok.valid = 1'b0; start_mode = M_BANG; end
         8'h3D: begin start_tok.valid = 1'b0; start_mode = M_EQ; end
         8'h3C: begin start_tok.valid = 1'b0; start_mode = M_LT; end
         8'h3E: begin start_tok.valid = 1'b0; start_mode = M_GT; end
         default: begin
            if (is_alpha) begin
               start_tok.valid = 1'b0;
               start_mode = M_WORD;
            end else begin
               start_tok.kind = K_ERROR;
            end
         end
      endcase
   end

   always_comb begin
      mode_in  = mode_ff;
      word_in  = word_ff;
      wlen_in  = wlen_ff;
      tline_in = tline_ff;
      tcol_in  = tcol_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      do_flush = 1'b0;
      do_start = 1'b0;
      pair_tok = '0;
      pair_tok.length = LEN_BITS'(2);
      if (in_end) begin
         do_flush = !(mode_ff inside {M_LCOMM, M_BCOMM, M_BSTAR});
         mode_in  = M_IDLE;
         tline_in = line_ff;
         tcol_in  = col_ff;
      end else begin
         case (mode_ff)
            M_WORD: begin
               if (is_word) begin
                  for (int i = 0; i < KEYWORD_CHARS; i++) begin
                     if (wlen_ff == LEN_BITS'(i)) word_in[8*i +: 8] = in_ch;
                  end
                  if (wlen_ff != '1) wlen_in = wlen_ff + LEN_BITS'(1);
               end else begin
                  do_flush = 1'b1;
                  do_start = 1'b1;
               end
            end
            M_SLASH: begin
               if (in_ch == 8'h2F) mode_in = M_LCOMM;
               else if (in_ch == 8'h2A) mode_in = M_BCOMM;
               else begin do_flush = 1'b1; do_start = 1'b1; end
            end
            M_LCOMM: if (in_ch == CH_NL) mode_in = M_IDLE;
            M_BCOMM: if (in_ch == 8'h2A) mode_in = M_BSTAR;
            M_BSTAR: begin
               if (in_ch == 8'h2F) mode_in = M_IDLE;
               else if (in_ch != 8'h2A) mode_in = M_BCOMM;
            end
            M_AMP, M_PIPE, M_BANG, M_EQ, M_LT, M_GT: begin
               pair_tok.valid = 1'b1;
               if (mode_ff == M_AMP && in_ch == 8'h26) pair_tok.kind = K_LAND;
               else if (mode_ff == M_PIPE && in_ch == 8'h7C) pair_tok.kind = K_LOR;
               else if (mode_ff == M_BANG && in_ch == 8'h3D) pair_tok.kind = K_NE;
               else if (mode_ff == M_EQ && in_ch == 8'h3D) pair_tok.kind = K_EQ;
               else if (mode_ff == M_LT && in_ch == 8'h3D) pair_tok.kind = K_LE;
               else if (mode_ff == M_LT && in_ch == 8'h3C) pair_tok.kind = K_SHL;
               else if (mode_ff == M_GT && in_ch == 8'h3D) pair_tok.kind = K_GE;
               else if (mode_ff == M_GT && in_ch == 8'h3E) pair_tok.kind = K_SHR;
               else pair_tok.valid = 1'b0;
               if (pair_tok.valid) mode_in = M_IDLE;
               else begin do_flush = 1'b1; do_start = 1'b1; end
            end
            default: do_start = 1'b1;
         endcase
         if (do_flush) mode_in = M_IDLE;
         if (do_start) begin
            tline_in = line_ff;
            tcol_in  = col_ff;
            mode_in  = start_mode;
            if (start_mode == M_WORD) begin
               word_in = WB'(in_ch);
               wlen_in = LEN_BITS'(1);
            end
         end
         if (in_ch == CH_NL) begin
            if (line_ff != '1) line_in = line_ff + LINE_BITS'(1);
            col_in = COL_BITS'(1);
         end else if (col_ff != '1) begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   // Results of this byte: flushed/pair token at the old start, then the new one.
   always_comb begin
      tok_type a, b;
      a = '0;
      b = '0;
      if (in_end) begin
         if (do_flush) a = flush_tok;
         b = '0;
         b.valid = 1'b1;
         b.kind = K_END;
         b.length = '0;
      end else if (pair_tok.valid) begin
         a = pair_tok;
      end else begin
         if (do_flush) a = flush_tok;
         if (do_start) b = start_tok;
      end
      q_first_line  = tline_ff;
      q_first_col   = tcol_ff;
      q_second_line = tline_in;
      q_second_col  = tcol_in;
      if (a.valid) begin
         q_first  = a;
         q_second = b;
      end else begin
         q_first       = b;
         q_second      = '0;
         q_first_line  = tline_in;
         q_first_col   = tcol_in;
      end
      q_first.at_word  = 1'b0;
      q_second.at_word = 1'b0;
   end

   assign q_push = take && q_first.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         word_ff  <= '0;
         wlen_ff  <= '0;
         line_ff  <= LINE_BITS'(1);
         col_ff   <= COL_BITS'(1);
         tline_ff <= LINE_BITS'(1);
         tcol_ff  <= COL_BITS'(1);
         done_ff  <= 1'b0;
      end else if (take) begin
         mode_ff  <= mode_in;
         word_ff  <= word_in;
         wlen_ff  <= wlen_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         tline_ff <= tline_in;
         tcol_ff  <= tcol_in;
         if (in_end) done_ff <= 1'b1;
      end
   end

`ifndef SYNTHESIS
   a_mode_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(mode_ff))
      else $error("scanner mode not one-hot");
   a_done_sticks: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> done_ff) else $error("finished flag dropped");
   a_idle_after_end: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> mode_ff == M_IDLE) else $error("mode active after end");
   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> q_room) else $error("push without room");
`endif
endmodule

/* design/clts_back.sv */
// Back end: token queue that serializes up to two results per byte onto the output.
`timescale 1ns / 1ps
module clts_back
   import clts_pkg::*;
#(
   parameter int LINE_BITS = 24,
   parameter int COL_BITS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_push,
   output logic                 q_room,
   input  tok_type              q_first,
   input  tok_type              q_second,
   input  logic [LINE_BITS-1:0] q_first_line,
   input  logic [COL_BITS-1:0]  q_first_col,
   input  logic [LINE_BITS-1:0] q_second_line,
   input  logic [COL_BITS-1:0]  q_second_col,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [KIND_BITS-1:0] out_kind,
   output logic [LINE_BITS-1:0] out_line,
   output logic [COL_BITS-1:0]  out_col,
   output logic [LEN_BITS-1:0]  out_length,
   output logic                 out_last
);
   localparam int EW = KIND_BITS + LINE_BITS + COL_BITS + LEN_BITS + 1;
   localparam int DEPTH = 4;
   localparam int AB = 2;

   logic [EW-1:0]  mem_ff [DEPTH];
   logic [AB-1:0]  wr_ff, rd_ff;
   logic [AB:0]    cnt_ff, cnt_in;
   logic           pop, two;
   logic [EW-1:0]  e0, e1;

   assign two = q_second.valid;
   assign e0 = {q_first.kind, q_first_line, q_first_col, q_first.length, !two};
   assign e1 = {q_second.kind, q_second_line, q_second_col, q_second.length, 1'b1};

   // Room for two entries keeps acceptance independent of the byte's content.
   assign q_room    = cnt_ff <= (AB+1)'(DEPTH - 2);
   assign out_valid = cnt_ff != '0;
   assign pop       = out_valid && out_ready;
   assign {out_kind, out_line, out_col, out_length, out_last} = mem_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff - (AB+1)'(pop);
      if (q_push) cnt_in = cnt_in + (two ? (AB+1)'(2) : (AB+1)'(1));
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         mem_ff[wr_ff] <= e0;
         if (two) mem_ff[wr_ff + AB'(1)] <= e1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (q_push) wr_ff <= wr_ff + (two ? AB'(2) : AB'(1));
         if (pop) rd_ff <= rd_ff + AB'(1);
         cnt_ff <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AB+1)'(DEPTH)) else $error("token queue overflow");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (!q_push && !pop) |=> $stable(cnt_ff)) else $error("queue count moved while idle");
   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      (q_push && two) |=> out_valid) else $error("pair pushed but queue empty");
`endif
endmodule

/* design/c_like_token_scanner.sv */
// Top level of the byte-serial C-like token scanner.
`timescale 1ns / 1ps
// The scanner takes one source byte, or an end-of-input mark, per request transaction and
// returns tokens on the response channel, each with its kind, start line, start column and
// length; the last response caused by a request has last_of_run set. Bytes stream at one
// per cycle while the response side keeps up: the front end classifies the byte and updates
// the scan mode and position counters as it accepts it, and a four-entry token queue holds
// the zero, one or two tokens each byte yields. A byte that yields two tokens takes two
// response transactions, so the sustained byte rate drops only for streams dense in such
// bytes. After the end token, further requests are accepted and ignored until reset.
module c_like_token_scanner
   import clts_pkg::*;
#(
   parameter int KEYWORD_CHARS = 6,
   parameter int LINE_BITS     = 24,
   parameter int COL_BITS      = 16
) (
   input logic clock,
   input logic reset,
   clts_if.sink   req,
   clts_if.source rsp
);
   tok_type              first, second;
   logic                 push, room;
   logic [LINE_BITS-1:0] fl, sl;
   logic [COL_BITS-1:0]  fc, sc;
   logic [KIND_BITS-1:0] kind;
   logic [LINE_BITS-1:0] line;
   logic [COL_BITS-1:0]  col;
   logic [LEN_BITS-1:0]  len;
   logic                 last;

   // Request payload is {end_of_input, ch}.
   clts_front #(.KEYWORD_CHARS(KEYWORD_CHARS), .LINE_BITS(LINE_BITS), .COL_BITS(COL_BITS))
   u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .in_ch(req.data[7:0]), .in_end(req.data[8]),
      .q_push(push), .q_room(room), .q_first(first), .q_second(second),
      .q_first_line(fl), .q_first_col(fc), .q_second_line(sl), .q_second_col(sc)
   );

   clts_back #(.LINE_BITS(LINE_BITS), .COL_BITS(COL_BITS)) u_back (
      .clock, .reset,
      .q_push(push), .q_room(room), .q_first(first), .q_second(second),
      .q_first_line(fl), .q_first_col(fc), .q_second_line(sl), .q_second_col(sc),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_kind(kind), .out_line(line), .out_col(col), .out_length(len), .out_last(last)
   );

   // Response payload is {kind, start_line, start_col, tok_length, last_of_run}.
   assign rsp.data = {kind, line, col, len, last};

`ifndef SYNTHESIS
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("response dropped while stalled");
   a_end_len: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && kind == K_END) |-> (len == '0 && last)) else $error("bad end token");
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (line != '0 && col != '0)) else $error("zero position");
`endif
endmodule

/* tb/c_like_token_scanner_tb.sv */
// Self-checking testbench of the byte-serial C-like token scanner.
`timescale 1ns / 1ps
module c_like_token_scanner_tb;
   import clts_pkg::*;

   localparam int KW_CHARS  = 6;
   localparam int LN_BITS   = 24;
   localparam int CL_BITS   = 16;
   localparam int REQ_W     = 9;
   localparam int RSP_W     = KIND_BITS + LN_BITS + CL_BITS + LEN_BITS + 1;
   localparam logic [LN_BITS-1:0]  LINE_TOP = '1;
   localparam logic [CL_BITS-1:0]  COL_TOP  = '1;
   localparam logic [LEN_BITS-1:0] LEN_TOP  = '1;

   // One request transaction: a source byte or the end mark.
   typedef struct packed {
      logic       end_of_input;
      logic [7:0] ch;
   } byte_item_t;

   // One token as it appears on the response channel.
   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [LN_BITS-1:0]   start_line;
      logic [CL_BITS-1:0]   start_col;
      logic [LEN_BITS-1:0]  tok_length;
      logic                 last_of_run;
   } token_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   clts_if #(.WIDTH(REQ_W)) req_if (.clock(clock));
   clts_if #(.WIDTH(RSP_W)) rsp_if (.clock(clock));

   c_like_token_scanner u_top (
      .clock(clock),
      .reset(reset),
      .req  (req_if),
      .rsp  (rsp_if)
   );

   always #10 clock = ~clock;

   // Source bytes waiting to be driven, and tokens waiting to be seen.
   byte_item_t source_bytes[$];
   token_t     pending_tokens[$];
   bit         stimulus_done = 1'b0;
   int         error_count = 0;
   int unsigned cycle_count = 0;

   // Predictor copy of the scanner state.
   mode_type        p_mode;
   logic [47:0]     p_word;
   logic [LEN_BITS-1:0] p_wlen;
   logic [LN_BITS-1:0]  p_line, p_tok_line;
   logic [CL_BITS-1:0]  p_col, p_tok_col;
   bit              p_done;

   // Queues a token at the current token start position.
   function automatic void push_token(logic [KIND_BITS-1:0] kind, int unsigned len);
      token_t t;
      t.kind        = kind;
      t.start_line  = p_tok_line;
      t.start_col   = p_tok_col;
      t.tok_length  = LEN_BITS'(len);
      t.last_of_run = 1'b0;
      pending_tokens.push_back(t);
   endfunction

   // Keyword lookup; words longer than the kept prefix are always identifiers.
   function automatic logic [KIND_BITS-1:0] classify_word();
      logic [KIND_BITS-1:0] k;
      k = K_IDENT;
      for (int i = 0; i < NUM_KW; i++) begin
         if (p_wlen == LEN_BITS'(KW_LEN[i]) && KW_LEN[i] <= KW_CHARS &&
             p_word == KW_TEXT[i][47:0]) begin
            k = KW_KIND[i];
         end
      end
      return k;
   endfunction

   // Emits the one-byte or word token that a pending mode holds.
   function automatic void flush_mode();
      case (p_mode)
         M_WORD:  push_token(classify_word(), p_wlen);
         M_SLASH: push_token(K_DIV, 1);
         M_AMP:   push_token(K_AND, 1);
         M_PIPE:  push_token(K_OR, 1);
         M_BANG:  push_token(K_NOT, 1);
         M_EQ:    push_token(K_ASSIGN, 1);
         M_LT:    push_token(K_LT, 1);
         M_GT:    push_token(K_GT, 1);
         default: ;
      endcase
      p_mode = M_IDLE;
   endfunction

   function automatic bit is_alpha(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
   endfunction

   // Opens a new token from an idle scanner.
   function automatic void open_token(logic [7:0] b);
      p_tok_line = p_line;
      p_tok_col  = p_col;
      case (b)
         CH_SP, CH_TAB, CH_NL: ;
         ",": push_token(K_COMMA, 1);
         ";": push_token(K_SEMI, 1);
         ":": push_token(K_COLON, 1);
         ".": push_token(K_DOT, 1);
         "(": push_token(K_LPAREN, 1);
         ")": push_token(K_RPAREN, 1);
         "{": push_token(K_LBRACE, 1);
         "}": push_token(K_RBRACE, 1);
         "[": push_token(K_LBRACK, 1);
         "]": push_token(K_RBRACK, 1);
         "+": push_token(K_PLUS, 1);
         "-": push_token(K_MINUS, 1);
         "*": push_token(K_STAR, 1);
         "%": push_token(K_MOD, 1);
         "^": push_token(K_XOR, 1);
         "~": push_token(K_TILDE, 1);
         "/": p_mode = M_SLASH;
         "&": p_mode = M_AMP;
         "|": p_mode = M_PIPE;
         "!": p_mode = M_BANG;
         "=": p_mode = M_EQ;
         "<": p_mode = M_LT;
         ">": p_mode = M_GT;
         default: begin
            if (is_alpha(b)) begin
               p_mode = M_WORD;
               p_word = 48'(b);
               p_wlen = LEN_BITS'(1);
            end else begin
               push_token(K_ERROR, 1);
            end
         end
      endcase
   endfunction

   // Pairs a pending operator byte with the next one; returns 1 if consumed.
   function automatic bit try_pair(logic [7:0] b);
      logic [KIND_BITS-1:0] k;
      bit hit;
      hit = 1'b1;
      k = K_ERROR;
      case (p_mode)
         M_AMP:  if (b == "&") k = K_LAND; else hit = 1'b0;
         M_PIPE: if (b == "|") k = K_LOR; else hit = 1'b0;
         M_BANG: if (b == "=") k = K_NE; else hit = 1'b0;
         M_EQ:   if (b == "=") k = K_EQ; else hit = 1'b0;
         M_LT:   if (b == "=") k = K_LE; else if (b == "<") k = K_SHL; else hit = 1'b0;
         M_GT:   if (b == "=") k = K_GE; else if (b == ">") k = K_SHR; else hit = 1'b0;
         default: hit = 1'b0;
      endcase
      if (hit) begin
         push_token(k, 2);
         p_mode = M_IDLE;
      end
      return hit;
   endfunction

   // Feeds one source byte through the scanner modes.
   function automatic void scan_byte(logic [7:0] b);
      bit consumed;
      consumed = 1'b0;
      case (p_mode)
         M_WORD: begin
            if (is_alpha(b) || (b >= "0" && b <= "9")) begin
               if (p_wlen < KW_CHARS) p_word = p_word | (48'(b) << (8 * p_wlen));
               if (p_wlen != LEN_TOP) p_wlen = p_wlen + LEN_BITS'(1);
               consumed = 1'b1;
            end
         end
         M_SLASH: begin
            if (b == "/") begin
               p_mode = M_LCOMM;
               consumed = 1'b1;
            end else if (b == "*") begin
               p_mode = M_BCOMM;
               consumed = 1'b1;
            end
         end
         M_LCOMM: begin
            if (b != CH_NL) consumed = 1'b1;
            else p_mode = M_IDLE;
         end
         M_BCOMM: begin
            if (b == "*") p_mode = M_BSTAR;
            consumed = 1'b1;
         end
         M_BSTAR: begin
            if (b == "/") p_mode = M_IDLE;
            else if (b != "*") p_mode = M_BCOMM;
            consumed = 1'b1;
         end
         M_IDLE: ;
         default: consumed = try_pair(b);
      endcase
      if (!consumed) begin
         flush_mode();
         open_token(b);
      end
   endfunction

   // Works out the tokens that one accepted transaction yields.
   function automatic void predict_tokens(byte_item_t it);
      int before_n;
      before_n = pending_tokens.size();
      if (p_done) return;
      if (it.end_of_input) begin
         // End of input inside a comment just closes it.
         if (p_mode != M_LCOMM && p_mode != M_BCOMM && p_mode != M_BSTAR) flush_mode();
         p_mode = M_IDLE;
         p_tok_line = p_line;
         p_tok_col  = p_col;
         push_token(K_END, 0);
         p_done = 1'b1;
      end else begin
         scan_byte(it.ch);
         if (it.ch == CH_NL) begin
            if (p_line != LINE_TOP) p_line = p_line + LN_BITS'(1);
            p_col = CL_BITS'(1);
         end else if (p_col != COL_TOP) begin
            p_col = p_col + CL_BITS'(1);
         end
      end
      if (pending_tokens.size() > before_n)
         pending_tokens[pending_tokens.size() - 1].last_of_run = 1'b1;
   endfunction

   function automatic void add_byte(logic [7:0] b);
      byte_item_t it;
      it.ch = b;
      it.end_of_input = 1'b0;
      source_bytes.push_back(it);
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic void add_end(logic [7:0] junk);
      byte_item_t it;
      it.ch = junk;
      it.end_of_input = 1'b1;
      source_bytes.push_back(it);
   endfunction

   // Random identifier of 1 to 9 bytes.
   function automatic string rand_ident();
      string s;
      string pool;
      int first;
      pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
      first = $urandom_range(0, 52);
      s = pool.substr(first, first);
      for (int i = $urandom_range(0, 8); i > 0; i--) begin
         int j;
         j = $urandom_range(0, 62);
         s = {s, pool.substr(j, j)};
      end
      return s;
   endfunction

   // A well-formed fragment of source text with random content.
   function automatic string rand_fragment();
      string frags [$];
      string s;
      frags = '{"break", "bool", "char", "const", "else", "for", "float", "if", "int",
                "return", "string", "use", "void", "while", "true", "false",
                ",", ";", ":", ".", "(", ")", "{", "}", "[", "]", "+", "-", "*", "/",
                "%", "&", "&&", "|", "||", "^", "~", "!", "!=", "=", "==", "<", "<=",
                "<<", ">", ">=", ">>", " ", "\t", "\n", "  ", "returns", "iff"};
      case ($urandom_range(0, 9))
         0, 1, 2: s = rand_ident();
         3:       s = {"//", rand_ident(), " x*/\n"};
         4:       s = {"/*", rand_ident(), "\n**", rand_ident(), "*/"};
         default: s = frags[$urandom_range(0, frags.size() - 1)];
      endcase
      return s;
   endfunction

   initial begin
      string tail;
      // Directed part: every keyword, punctuator and operator, comments, errors.
      add_text("break bool char const else for float if int return string use void\n");
      add_text("while true false _x9 Zz,;:.(){}[]+-*%^~ & && | || ! != = == <");
      add_text(" <= << > >= >> / x/*a\n*/b//c*/\n9\"'\r");
      add_byte(8'hFF);
      add_byte(8'h80);
      add_byte(8'h00);
      add_text("a&b|c!d=e<f>g/h***/i/**/\t");
      // Random part: mostly well-formed fragments, some raw noise bytes.
      for (int n = 0; n < 730; ) begin
         if ($urandom_range(0, 99) < 15) begin
            add_byte(8'($urandom_range(0, 255)));
            n++;
         end else begin
            tail = rand_fragment();
            add_text(tail);
            n += tail.len();
         end
      end
      add_text(" ;\n");
      // End the source in a randomly chosen state.
      case ($urandom_range(0, 3))
         0:       add_text("/* open");
         1:       add_text("// open");
         2:       add_text("x<");
         default: add_text("abc");
      endcase
      add_end(8'($urandom_range(0, 255)));
      // Anything after the end mark must be ignored.
      for (int i = 0; i < 6; i++) add_byte(8'($urandom_range(0, 255)));
      add_end(8'h00);
   end

   // Idling is off for a long stretch in the middle of the run.
   function automatic bit want_idle();
      if (cycle_count > 400 && cycle_count < 800) return 1'b0;
      return $urandom_range(0, 99) < 38;
   endfunction

   // Request and response-ready driver: changes inputs at the falling edge only.
   bit req_taken = 1'b0;
   initial begin
      req_if.valid = 1'b0;
      req_if.data  = '0;
      rsp_if.ready = 1'b0;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_if.valid || req_taken) begin
            if (source_bytes.size() > 0 && !want_idle()) begin
               req_if.valid <= 1'b1;
               req_if.data  <= source_bytes.pop_front();
            end else begin
               req_if.valid <= 1'b0;
               if (source_bytes.size() == 0) stimulus_done = 1'b1;
            end
         end
         rsp_if.ready <= !want_idle();
      end
      req_taken = 1'b0;
   end

   // Monitor: samples both channels at the rising edge.
   always @(posedge clock) begin
      token_t got, want;
      cycle_count++;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            predict_tokens(byte_item_t'(req_if.data));
            req_taken = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = token_t'(rsp_if.data);
            if (pending_tokens.size() == 0) begin
               $error("unexpected token transaction: kind %0d", got.kind);
               error_count++;
            end else begin
               want = pending_tokens.pop_front();
               if (got.kind != want.kind) begin
                  $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                  error_count++;
               end
               if (got.start_line != want.start_line) begin
                  $error("start_line: expected %0d, actual %0d",
                         want.start_line, got.start_line);
                  error_count++;
               end
               if (got.start_col != want.start_col) begin
                  $error("start_col: expected %0d, actual %0d", want.start_col, got.start_col);
                  error_count++;
               end
               if (got.tok_length != want.tok_length) begin
                  $error("tok_length: expected %0d, actual %0d",
                         want.tok_length, got.tok_length);
                  error_count++;
               end
               if (got.last_of_run != want.last_of_run) begin
                  $error("last_of_run: expected %0d, actual %0d",
                         want.last_of_run, got.last_of_run);
                  error_count++;
               end
            end
         end
      end
   end

   // Reset, then wait for all transactions to drain and report.
   initial begin
      p_mode     = M_IDLE;
      p_word     = '0;
      p_wlen     = '0;
      p_line     = LN_BITS'(1);
      p_col      = CL_BITS'(1);
      p_tok_line = LN_BITS'(1);
      p_tok_col  = CL_BITS'(1);
      p_done     = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done && !req_if.valid);
      wait (pending_tokens.size() == 0);
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_tokens.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #40ms;
      $display("tb: failure");
      $finish;
   end

endmodule

/* files.f */
design/clts_pkg.sv
design/clts_if.sv
design/clts_front.sv
design/clts_back.sv
design/c_like_token_scanner.sv
tb/c_like_token_scanner_tb.sv
